/* rtl/sdds_pkg.sv */
// ---------------------------------------------------------------------------
// sdds_pkg
// Shared types and constants for the stereo sine synthesizer.
// ---------------------------------------------------------------------------
package sdds_pkg;

    localparam int TABLE_DEPTH = 2048;
    localparam int FRAC_BITS   = 16;
    localparam int INDEX_W     = $clog2(TABLE_DEPTH);
    localparam int PHASE_W     = INDEX_W + FRAC_BITS;
    localparam int SAMPLE_W    = 24;
    localparam int BANK_DEPTH  = TABLE_DEPTH / 2;
    localparam int BANK_AW     = INDEX_W - 1;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int PROD_W      = DIFF_W + FRAC_BITS + 1;
    localparam int CFG_IDX_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_INC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_INC = 2'd1;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic [INDEX_W-1:0]         table_index;
        logic signed [SAMPLE_W-1:0] table_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } out_item_t;

    // per-channel info riding along with a table read
    typedef struct packed {
        logic                 lo_odd;
        logic [FRAC_BITS-1:0] frac;
    } tap_sel_t;

endpackage

/* rtl/sdds_ram.sv */
// ---------------------------------------------------------------------------
// sdds_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module sdds_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* rtl/sdds_interp.sv */
// ---------------------------------------------------------------------------
// sdds_interp
// One channel: picks the two neighbor entries out of the even/odd banks,
// registers the slope product, then adds the truncated step.
// ---------------------------------------------------------------------------
module sdds_interp (
    input  logic                                clk,
    input  logic                                adv,
    input  sdds_pkg::tap_sel_t                  sel,
    input  logic [sdds_pkg::SAMPLE_W-1:0]       even_data,
    input  logic [sdds_pkg::SAMPLE_W-1:0]       odd_data,
    output logic signed [sdds_pkg::SAMPLE_W-1:0] sample
);

    import sdds_pkg::*;

    localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);

    logic signed [SAMPLE_W-1:0]  v1;
    logic signed [SAMPLE_W-1:0]  v2;
    logic signed [DIFF_W-1:0]    diff;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [SAMPLE_W-1:0]  v1_reg;
    logic signed [PROD_W-1:0]    adj;

    always_comb
    begin
        v1     = sel.lo_odd ? odd_data : even_data;
        v2     = sel.lo_odd ? even_data : odd_data;
        diff   = $signed({v2[SAMPLE_W-1], v2}) - $signed({v1[SAMPLE_W-1], v1});
        frac_s = $signed({1'b0, sel.frac});
        prod   = PROD_W'(diff) * PROD_W'(frac_s);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod;
            v1_reg   <= v1;
        end
    end

    // arithmetic shift rounds toward minus infinity; bias negatives to truncate toward zero
    always_comb
    begin
        adj    = prod_reg + (prod_reg[PROD_W-1] ? TRUNC_BIAS : '0);
        sample = v1_reg + adj[FRAC_BITS +: SAMPLE_W];
    end

endmodule

/* rtl/stereo_dds_sine_interp_unit.sv */
// ---------------------------------------------------------------------------
// stereo_dds_sine_interp_unit
// Stereo phase-accumulator synthesizer with linear table interpolation.
// ---------------------------------------------------------------------------
// Pipeline: a tick transfer reads the table at its accepting edge, then the slope
//   product is registered, then the step add goes into the output register.
// Throughput: one item per cycle; the table is split into even/odd banks so
//   the four neighbor reads of a tick fit the two read ports of each bank.
//   A held-off result freezes the whole pipe and stalls the input.
// Reset: phases and increments clear to zero; table contents are not cleared.
module stereo_dds_sine_interp_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  sdds_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output sdds_pkg::out_item_t                  out_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sdds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sdds_pkg::PHASE_W-1:0]         cfg_data
);

    import sdds_pkg::*;

    logic [PHASE_W-1:0] left_inc_reg;
    logic [PHASE_W-1:0] right_inc_reg;
    logic [PHASE_W-1:0] left_phase_reg;
    logic [PHASE_W-1:0] right_phase_reg;
    logic [PHASE_W-1:0] left_phase_next;
    logic [PHASE_W-1:0] right_phase_next;

    logic adv;
    logic in_xfer;
    logic tick_xfer;
    logic wr_xfer;

    logic     s1_valid_reg;
    logic     s2_valid_reg;
    logic     out_valid_reg;
    tap_sel_t left_sel_reg;
    tap_sel_t right_sel_reg;
    out_item_t out_item_reg;

    logic [INDEX_W-1:0] left_lo;
    logic [INDEX_W-1:0] right_lo;
    logic [INDEX_W-1:0] left_hi;
    logic [INDEX_W-1:0] right_hi;

    logic [SAMPLE_W-1:0] even_left;
    logic [SAMPLE_W-1:0] even_right;
    logic [SAMPLE_W-1:0] odd_left;
    logic [SAMPLE_W-1:0] odd_right;

    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    // whole pipeline moves unless a finished result is held off
    assign adv       = !(out_valid_reg && out_stall);
    assign in_stall  = !adv;
    assign in_xfer   = in_valid && adv;
    assign tick_xfer = in_xfer && (in_item.cmd == CMD_TICK);
    assign wr_xfer   = in_xfer && (in_item.cmd == CMD_WRITE);
    assign cfg_ready = 1'b1;

    // phase wraps modulo the table span by plain overflow
    assign left_phase_next  = left_phase_reg + left_inc_reg;
    assign right_phase_next = right_phase_reg + right_inc_reg;

    assign left_lo  = left_phase_next[FRAC_BITS +: INDEX_W];
    assign right_lo = right_phase_next[FRAC_BITS +: INDEX_W];
    assign left_hi  = left_lo + INDEX_W'(1);
    assign right_hi = right_lo + INDEX_W'(1);

    // entry lo and lo+1 always land in opposite banks: the odd one of the
    // pair sits at lo>>1, the even one at (lo+1)>>1 (wraps to entry 0)
    sdds_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .clk     (clk),
        .we      (wr_xfer && !in_item.table_index[0]),
        .waddr   (in_item.table_index[INDEX_W-1:1]),
        .wdata   (in_item.table_value),
        .re      (tick_xfer),
        .raddr_a (left_hi[INDEX_W-1:1]),
        .raddr_b (right_hi[INDEX_W-1:1]),
        .rdata_a (even_left),
        .rdata_b (even_right)
    );

    sdds_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .clk     (clk),
        .we      (wr_xfer && in_item.table_index[0]),
        .waddr   (in_item.table_index[INDEX_W-1:1]),
        .wdata   (in_item.table_value),
        .re      (tick_xfer),
        .raddr_a (left_lo[INDEX_W-1:1]),
        .raddr_b (right_lo[INDEX_W-1:1]),
        .rdata_a (odd_left),
        .rdata_b (odd_right)
    );

    sdds_interp u_left (
        .clk       (clk),
        .adv       (adv),
        .sel       (left_sel_reg),
        .even_data (even_left),
        .odd_data  (odd_left),
        .sample    (left_sample)
    );

    sdds_interp u_right (
        .clk       (clk),
        .adv       (adv),
        .sel       (right_sel_reg),
        .even_data (even_right),
        .odd_data  (odd_right),
        .sample    (right_sample)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_inc_reg  <= '0;
            right_inc_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LEFT_INC:  left_inc_reg  <= cfg_data;
                REG_RIGHT_INC: right_inc_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_phase_reg  <= '0;
            right_phase_reg <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            if (tick_xfer)
            begin
                left_phase_reg  <= left_phase_next;
                right_phase_reg <= right_phase_next;
            end
            s1_valid_reg  <= tick_xfer;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            left_sel_reg.lo_odd  <= left_lo[0];
            left_sel_reg.frac    <= left_phase_next[FRAC_BITS-1:0];
            right_sel_reg.lo_odd <= right_lo[0];
            right_sel_reg.frac   <= right_phase_next[FRAC_BITS-1:0];
        end
        if (adv && s2_valid_reg)
        begin
            out_item_reg.left_sample  <= left_sample;
            out_item_reg.right_sample <= right_sample;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
